/* sv/mat4_vec4_transform_macros.svh */
// ----------------------------------------------------------------------------
// mat4_vec4_transform assertion macros
// Concurrent assertion wrappers clocked on aclk. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MAT4_VEC4_TRANSFORM_MACROS_SVH
`define MAT4_VEC4_TRANSFORM_MACROS_SVH
`ifndef SYNTHESIS
// Checked outside reset only.
`define MV4_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("mat4_vec4_transform: assertion failed");
// Checked at every edge, reset included.
`define MV4_ASSERT_RST(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("mat4_vec4_transform: reset assertion failed");
`else
`define MV4_ASSERT(label, prop)
`define MV4_ASSERT_RST(label, prop)
`endif
`endif

/* sv/mv4_pkg.sv */
// ----------------------------------------------------------------------------
// mv4_pkg
// Shared types and constants of the 4x4 matrix by 4-vector transform block.
// ----------------------------------------------------------------------------
`default_nettype none

package mv4_pkg;

    // Signed fixed-point word and its fractional bits (Q16.16).
    localparam int WORD_WIDTH  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int PROD_WIDTH  = 2 * WORD_WIDTH;
    localparam int PAIR_WIDTH  = PROD_WIDTH + 1;
    localparam int SUM_WIDTH   = PROD_WIDTH + 2;
    localparam int DIM         = 4;
    localparam int COL_WIDTH   = $clog2(DIM);
    localparam int QUEUE_DEPTH = 2;

    typedef logic signed [WORD_WIDTH-1:0] word_t;
    typedef logic signed [PROD_WIDTH-1:0] prod_t;
    typedef logic signed [PAIR_WIDTH-1:0] pair_t;
    typedef logic signed [SUM_WIDTH-1:0]  sum_t;
    typedef logic [COL_WIDTH-1:0]         col_t;

    localparam word_t FIX_ONE  = word_t'(64'(1) << FRAC_BITS);
    localparam word_t WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

    typedef enum logic {
        OP_LOAD      = 1'b0,
        OP_TRANSFORM = 1'b1
    } op_t;

    // One input beat.
    typedef struct packed {
        op_t   operation;
        col_t  column_index;
        word_t comp_x;
        word_t comp_y;
        word_t comp_z;
        word_t comp_w;
    } in_item_t;

    // One result beat.
    typedef struct packed {
        word_t out_x;
        word_t out_y;
        word_t out_z;
        word_t out_w;
        logic  saturated;
    } out_item_t;

    // A classified item as it waits in the queue between front and back.
    typedef struct packed {
        logic                is_load;
        col_t                col;
        word_t [DIM-1:0]     vec;
    } q_item_t;

endpackage

`default_nettype wire

/* sv/mat4_vec4_transform.sv */
// A transform beat passes the front register, the queue and the three back stages before it shows on m_valid.
// Throughput: one beat per cycle, loads and transforms alike, while m_ready does
// not stall the back pipeline, which issues to sixteen parallel multipliers.
// A load beat changes the matrix in order with transforms and gives no result.
// Reset (aresetn low, synchronous) empties all stages and sets the matrix to identity.
// ----------------------------------------------------------------------------
// mat4_vec4_transform
// 4x4 signed Q16.16 matrix by 4-vector transform with column loads.
// ----------------------------------------------------------------------------
`default_nettype none

module mat4_vec4_transform (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire mv4_pkg::in_item_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output mv4_pkg::out_item_t     m_data
);

    // The front registers each input beat and marks it as a column load or a
    // transform. The queue between front and back lets either side stall on
    // its own without losing throughput.
    logic             fq_valid;
    logic             fq_ready;
    mv4_pkg::q_item_t fq_item;

    // The back pops beats in order. A load writes its column straight into the
    // matrix registers at pop time, so any transform popped later sees it and
    // any transform popped earlier has already taken its products.
    logic             qb_valid;
    logic             qb_ready;
    mv4_pkg::q_item_t qb_item;

    mv4_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_item  (fq_item)
    );

    mv4_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    // Products, pairwise sums, then the final sum with a floored shift by the
    // fraction width and saturation; the last stage is the output register.
    mv4_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_item  (qb_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

/* sv/mv4_front.sv */
// ----------------------------------------------------------------------------
// mv4_front
// Input register stage: takes beats from the input channel and classifies
// them as column loads or transforms for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mv4_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire mv4_pkg::in_item_t s_data,
    output logic                   q_valid,
    input  wire logic              q_ready,
    output mv4_pkg::q_item_t       q_item
);

    logic             valid_reg;
    mv4_pkg::q_item_t item_reg;
    mv4_pkg::q_item_t item_next;

    assign s_ready = !valid_reg || q_ready;
    assign q_valid = valid_reg;
    assign q_item  = item_reg;

    always_comb begin
        item_next.is_load = (s_data.operation == mv4_pkg::OP_LOAD);
        item_next.col     = s_data.column_index;
        item_next.vec[0]  = s_data.comp_x;
        item_next.vec[1]  = s_data.comp_y;
        item_next.vec[2]  = s_data.comp_z;
        item_next.vec[3]  = s_data.comp_w;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

/* sv/mv4_queue.sv */
// ----------------------------------------------------------------------------
// mv4_queue
// Short first-in first-out queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mat4_vec4_transform_macros.svh"

module mv4_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire mv4_pkg::q_item_t in_item,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output mv4_pkg::q_item_t      out_item
);

    localparam int PTR_WIDTH = (mv4_pkg::QUEUE_DEPTH > 1) ? $clog2(mv4_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_WIDTH = $clog2(mv4_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_WIDTH-1:0] DEPTH_CNT = CNT_WIDTH'(mv4_pkg::QUEUE_DEPTH);
    localparam logic [PTR_WIDTH-1:0] LAST_PTR  = PTR_WIDTH'(mv4_pkg::QUEUE_DEPTH - 1);

    mv4_pkg::q_item_t     mem_reg [mv4_pkg::QUEUE_DEPTH];
    logic [PTR_WIDTH-1:0] wr_ptr_reg;
    logic [PTR_WIDTH-1:0] rd_ptr_reg;
    logic [CNT_WIDTH-1:0] count_reg;
    logic                 push;
    logic                 pop;

    assign in_ready  = (count_reg != DEPTH_CNT);
    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    `MV4_ASSERT(a_count_up, (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
    `MV4_ASSERT(a_count_down, (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
    `MV4_ASSERT(a_empty_ptrs, (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))

endmodule

`default_nettype wire

/* sv/mv4_back.sv */
// ----------------------------------------------------------------------------
// mv4_back
// Matrix store and three-stage multiply, add and saturate pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mat4_vec4_transform_macros.svh"

module mv4_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             q_valid,
    output logic                  q_ready,
    input  wire mv4_pkg::q_item_t q_item,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output mv4_pkg::out_item_t    m_data
);

    localparam int DIM     = mv4_pkg::DIM;
    localparam int TOP_LSB = mv4_pkg::WORD_WIDTH - 1;

    mv4_pkg::word_t     matrix_reg [DIM][DIM];  // [column][row]
    mv4_pkg::prod_t     prod_reg   [DIM][DIM];  // [row][column]
    mv4_pkg::prod_t     prod_next  [DIM][DIM];
    mv4_pkg::pair_t     pair_reg   [DIM][2];
    mv4_pkg::pair_t     pair_next  [DIM][2];
    mv4_pkg::out_item_t out_reg;
    mv4_pkg::out_item_t out_next;
    logic               p1_valid_reg;
    logic               p2_valid_reg;
    logic               p3_valid_reg;
    logic               p1_ready;
    logic               p2_ready;
    logic               p3_ready;
    logic               pop;

    // Each stage moves on when the stage after it has room.
    assign p3_ready = !p3_valid_reg || m_ready;
    assign p2_ready = !p2_valid_reg || p3_ready;
    assign p1_ready = !p1_valid_reg || p2_ready;
    assign q_ready  = q_item.is_load || p1_ready;
    assign pop      = q_valid && q_ready;
    assign m_valid  = p3_valid_reg;
    assign m_data   = out_reg;

    // Stage 1: sixteen products against the matrix as it stands at pop time.
    always_comb begin
        for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
                prod_next[r][c] = mv4_pkg::prod_t'($signed(matrix_reg[c][r]))
                                * mv4_pkg::prod_t'($signed(q_item.vec[c]));
            end
        end
    end

    // Stage 2: pairwise sums per row.
    always_comb begin
        for (int r = 0; r < DIM; r++) begin
            for (int h = 0; h < 2; h++) begin
                pair_next[r][h] = mv4_pkg::pair_t'(prod_reg[r][2*h])
                                + mv4_pkg::pair_t'(prod_reg[r][2*h+1]);
            end
        end
    end

    // Stage 3: full sum, floored shift and saturation to one word.
    always_comb begin
        mv4_pkg::sum_t  sum;
        mv4_pkg::sum_t  shifted;
        logic           clip   [DIM];
        mv4_pkg::word_t res    [DIM];
        for (int r = 0; r < DIM; r++) begin
            sum     = mv4_pkg::sum_t'(pair_reg[r][0]) + mv4_pkg::sum_t'(pair_reg[r][1]);
            shifted = sum >>> mv4_pkg::FRAC_BITS;
            clip[r] = !(&shifted[mv4_pkg::SUM_WIDTH-1:TOP_LSB])
                   && (|shifted[mv4_pkg::SUM_WIDTH-1:TOP_LSB]);
            if (clip[r]) begin
                res[r] = shifted[mv4_pkg::SUM_WIDTH-1] ? mv4_pkg::WORD_MIN
                                                        : mv4_pkg::WORD_MAX;
            end else begin
                res[r] = shifted[mv4_pkg::WORD_WIDTH-1:0];
            end
        end
        out_next.out_x     = res[0];
        out_next.out_y     = res[1];
        out_next.out_z     = res[2];
        out_next.out_w     = res[3];
        out_next.saturated = clip[0] || clip[1] || clip[2] || clip[3];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < DIM; c++) begin
                for (int r = 0; r < DIM; r++) begin
                    matrix_reg[c][r] <= (c == r) ? mv4_pkg::FIX_ONE : '0;
                end
            end
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end else begin
            if (pop && q_item.is_load) begin
                for (int r = 0; r < DIM; r++) begin
                    matrix_reg[q_item.col][r] <= q_item.vec[r];
                end
            end
            if (p1_ready) begin
                p1_valid_reg <= pop && !q_item.is_load;
            end
            if (p2_ready) begin
                p2_valid_reg <= p1_valid_reg;
            end
            if (p3_ready) begin
                p3_valid_reg <= p2_valid_reg;
            end
        end
        if (pop && !q_item.is_load) begin
            prod_reg <= prod_next;
        end
        if (p2_ready && p1_valid_reg) begin
            pair_reg <= pair_next;
        end
        if (p3_ready && p2_valid_reg) begin
            out_reg <= out_next;
        end
    end

    `MV4_ASSERT(a_load_no_result, (pop && q_item.is_load && p1_ready) |=> !p1_valid_reg)
    `MV4_ASSERT(a_transform_enters, (pop && !q_item.is_load) |=> p1_valid_reg)
    `MV4_ASSERT(a_stall_holds, (p3_valid_reg && !m_ready) |=> (p3_valid_reg && $stable(out_reg)))
    `MV4_ASSERT_RST(a_reset_identity, !aresetn |=> (matrix_reg[0][0] == mv4_pkg::FIX_ONE))

endmodule

`default_nettype wire
